FILE: rtl/csfr_pkg.sv
// Shared types and constants for the compact-support field remap unit.
`timescale 1ns / 1ps
`default_nettype none

package csfr_pkg;

    // Fractional bits of distance, radius and field value.
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 32;
    localparam int RAD_W     = 31;
    localparam int OUT_W     = FRAC_BITS + 1;
    // Fractional bits of the normalised magnitude and of the polynomial terms.
    localparam int Q_BITS    = 30;
    localparam int PROD_W    = 2 * Q_BITS;
    localparam int H_W       = Q_BITS + 2;

    localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(1) << FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_ONE   = OUT_W'(1) << FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_ZERO  = '0;

    // Polynomial coefficients in Q1.30.
    localparam logic [Q_BITS+1:0] T_C0   = (Q_BITS + 2)'(5) << (Q_BITS - 3);
    localparam logic [Q_BITS+1:0] U_C0   = (Q_BITS + 2)'(15) << (Q_BITS - 4);
    localparam logic [H_W-1:0]    H_HALF = H_W'(1) << (Q_BITS - 1);
    localparam logic [H_W-1:0]    H_RND  = H_W'(1) << (Q_BITS - 1 - FRAC_BITS);
    localparam int                H_SH   = Q_BITS - FRAC_BITS;

    // One beat travelling down the divider chain.
    typedef struct packed {
        logic              valid;
        logic              sat;
        logic              sat_one;
        logic              neg;
        logic [RAD_W-1:0]  rem;
        logic [Q_BITS-1:0] quo;
    } t_div_beat;

    // Control carried alongside the polynomial stages.
    typedef struct packed {
        logic valid;
        logic sat;
        logic sat_one;
        logic neg;
    } t_poly_ctl;

endpackage

`default_nettype wire

FILE: rtl/csfr_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
`timescale 1ns / 1ps
`default_nettype none

module csfr_div_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire logic [csfr_pkg::RAD_W-1:0]  i_radius,
    input  wire csfr_pkg::t_div_beat         i_beat,
    output csfr_pkg::t_div_beat              o_beat
);

    logic [csfr_pkg::RAD_W:0] w_rem2;
    logic [csfr_pkg::RAD_W:0] w_diff;
    logic                     w_take;
    csfr_pkg::t_div_beat      n_beat;
    csfr_pkg::t_div_beat      r_beat;
    logic                     r_valid;

    assign w_rem2 = {i_beat.rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, i_radius};
    assign w_take = (w_rem2 >= {1'b0, i_radius});

    always_comb begin
        n_beat     = i_beat;
        n_beat.rem = w_take ? w_diff[csfr_pkg::RAD_W-1:0]
                            : w_rem2[csfr_pkg::RAD_W-1:0];
        n_beat.quo = {i_beat.quo[csfr_pkg::Q_BITS-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_beat <= n_beat;
        end
    end

    always_comb begin
        o_beat       = r_beat;
        o_beat.valid = r_valid;
    end

endmodule

`default_nettype wire

FILE: rtl/csfr_poly.sv
// Pipelined quintic evaluation, rounding and clamping of the normalised magnitude.
`timescale 1ns / 1ps
`default_nettype none

module csfr_poly (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire csfr_pkg::t_div_beat         i_beat,
    output logic                             o_valid,
    output logic [csfr_pkg::OUT_W-1:0]       o_value
);

    localparam int QB = csfr_pkg::Q_BITS;
    localparam int PW = csfr_pkg::PROD_W;
    localparam int HW = csfr_pkg::H_W;

    csfr_pkg::t_poly_ctl r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [QB-1:0]       r_a1, r_a2, r_a3;
    logic [QB-1:0]       r_sq1, r_sq2;
    logic [QB-1:0]       r_t2;
    logic [QB-1:0]       r_u3;
    logic [QB-1:0]       r_g4;
    logic                r_valid;
    logic [csfr_pkg::OUT_W-1:0] r_value;

    logic [PW-1:0]       w_sq_prod, w_at_prod, w_g_prod;
    logic [QB+1:0]       w_three_sq;
    logic [QB+1:0]       w_t_full, w_u_full;
    logic [HW-1:0]       w_h, w_hr;
    logic [HW-1:0]       w_r;
    logic [csfr_pkg::OUT_W-1:0] n_value;

    // stage 1: a^2
    assign w_sq_prod  = PW'(i_beat.quo) * PW'(i_beat.quo);
    // stage 2: t = 5/8 - 3/16 a^2
    assign w_three_sq = {1'b0, r_sq1, 1'b0} + {2'b00, r_sq1};
    assign w_t_full   = csfr_pkg::T_C0 - (w_three_sq >> 4);
    // stage 3: u = 15/16 - a^2 t
    assign w_at_prod  = PW'(r_sq2) * PW'(r_t2);
    assign w_u_full   = csfr_pkg::U_C0 - {2'b00, w_at_prod[PW-1:QB]};
    // stage 4: g = a u
    assign w_g_prod   = PW'(r_a3) * PW'(r_u3);

    // stage 5: fold in the sign, round to nearest, clamp
    assign w_h  = r_ctl4.neg ? (csfr_pkg::H_HALF + {2'b00, r_g4})
                             : (csfr_pkg::H_HALF - {2'b00, r_g4});
    assign w_hr = w_h + csfr_pkg::H_RND;
    assign w_r  = w_hr >> csfr_pkg::H_SH;

    always_comb begin
        if (r_ctl4.sat) begin
            n_value = r_ctl4.sat_one ? csfr_pkg::OUT_ONE : csfr_pkg::OUT_ZERO;
        end else if (w_h[HW-1]) begin
            // a difference below zero wraps huge and clamps to one
            n_value = csfr_pkg::OUT_ONE;
        end else if (w_r > HW'(csfr_pkg::OUT_ONE)) begin
            n_value = csfr_pkg::OUT_ONE;
        end else begin
            n_value = w_r[csfr_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
            r_ctl3.valid <= 1'b0;
            r_ctl4.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else if (i_advance) begin
            r_ctl1.valid   <= i_beat.valid;
            r_ctl1.sat     <= i_beat.sat;
            r_ctl1.sat_one <= i_beat.sat_one;
            r_ctl1.neg     <= i_beat.neg;
            r_a1           <= i_beat.quo;
            r_sq1          <= w_sq_prod[PW-1:QB];

            r_ctl2.valid   <= r_ctl1.valid;
            r_ctl2.sat     <= r_ctl1.sat;
            r_ctl2.sat_one <= r_ctl1.sat_one;
            r_ctl2.neg     <= r_ctl1.neg;
            r_a2           <= r_a1;
            r_sq2          <= r_sq1;
            r_t2           <= w_t_full[QB-1:0];

            r_ctl3.valid   <= r_ctl2.valid;
            r_ctl3.sat     <= r_ctl2.sat;
            r_ctl3.sat_one <= r_ctl2.sat_one;
            r_ctl3.neg     <= r_ctl2.neg;
            r_a3           <= r_a2;
            r_u3           <= w_u_full[QB-1:0];

            r_ctl4.valid   <= r_ctl3.valid;
            r_ctl4.sat     <= r_ctl3.sat;
            r_ctl4.sat_one <= r_ctl3.sat_one;
            r_ctl4.neg     <= r_ctl3.neg;
            r_g4           <= w_g_prod[PW-1:QB];

            r_valid        <= r_ctl4.valid;
            r_value        <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: rtl/compact_support_field_remap_unit.sv
// Top level of the compact-support field remap unit: front stage, divider chain, polynomial.
`timescale 1ns / 1ps
`default_nettype none

// Maps a signed Q15.16 distance to a field value in unsigned Q1.16 (65536 is 1.0).
// A distance at or below minus the support radius gives 1.0, one at or above the
// radius gives 0.0; in between x = distance / radius is formed and the quintic
// 1/2 - 15/16 x + 5/8 x^3 - 3/16 x^5 is evaluated, rounded to nearest and clamped.
// The unit takes one sample per clock while outputs are taken and returns one value
// per sample, in order, through one front stage (bound compares and magnitude), a
// chain of 30 division cells that each settle one quotient bit of |x|, four
// polynomial stages and the output register. The 30-cell divider chain sets the
// latency; throughput is one beat per cycle whenever the output side takes beats.
// The whole pipeline holds while a finished value waits to be taken, so the input
// is ready whenever the output register is empty or being read. Write the support
// radius only while no sample is in flight; it resets to 1.0.

module compact_support_field_remap_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [csfr_pkg::RAD_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [csfr_pkg::DIST_W-1:0] i_distance,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [csfr_pkg::OUT_W-1:0]              o_field_value
);

    localparam int NCELL = csfr_pkg::Q_BITS;
    localparam int DW    = csfr_pkg::DIST_W;

    logic [csfr_pkg::RAD_W-1:0] r_support_radius;
    logic                       w_advance;
    logic                       w_out_valid;

    // Front stage signals
    logic signed [DW:0]         w_dist_x;
    logic signed [DW:0]         w_rad_x;
    logic                       w_at_low;
    logic                       w_at_high;
    logic [DW-1:0]              w_abs;
    csfr_pkg::t_div_beat        n_front;
    csfr_pkg::t_div_beat        r_front;
    logic                       r_front_valid;

    csfr_pkg::t_div_beat        w_chain [0:NCELL];

    // Hold the whole pipeline while the output register is full and not taken.
    assign w_advance  = !w_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    // Radius register: keep the low 31 bits of each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_support_radius <= csfr_pkg::RAD_RESET;
        end else if (i_cfg_we) begin
            r_support_radius <= i_cfg_wdata;
        end
    end

    // Exact bound compares on the raw integers; a zero radius falls out of these too.
    assign w_dist_x  = {i_distance[DW-1], i_distance};
    assign w_rad_x   = {2'b00, r_support_radius};
    assign w_at_low  = (w_dist_x <= -w_rad_x);
    assign w_at_high = (w_dist_x >= w_rad_x);
    assign w_abs     = i_distance[DW-1] ? (DW'(0) - i_distance) : i_distance;

    always_comb begin
        n_front         = '0;
        n_front.valid   = i_in_valid;
        n_front.sat     = w_at_low || w_at_high;
        n_front.sat_one = w_at_low;
        n_front.neg     = i_distance[DW-1];
        // Magnitude is below the radius whenever it is used, so it fits.
        n_front.rem     = w_abs[csfr_pkg::RAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_advance) begin
            r_front_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_front <= n_front;
        end
    end

    always_comb begin
        w_chain[0]       = r_front;
        w_chain[0].valid = r_front_valid;
    end

    // Divider chain: each cell doubles the remainder and takes one quotient bit.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        csfr_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_radius  (r_support_radius),
            .i_beat    (w_chain[k]),
            .o_beat    (w_chain[k+1])
        );
    end

    // Quintic, rounding, clamping and the output register.
    csfr_poly u_poly (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_beat    (w_chain[NCELL]),
        .o_valid   (w_out_valid),
        .o_value   (o_field_value)
    );

    assign o_out_valid = w_out_valid;

endmodule

`default_nettype wire

FILE: rtl/csfr_checker.sv
// Port-level checker for the compact-support field remap unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module csfr_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_cfg_we,
    input wire logic [csfr_pkg::RAD_W-1:0]         i_cfg_wdata,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic signed [csfr_pkg::DIST_W-1:0] i_distance,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [csfr_pkg::OUT_W-1:0]         o_field_value
);

    // A stalled beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled beat keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_field_value))
        else $error("output value changed while stalled");

    // Field values never exceed 1.0.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_field_value <= csfr_pkg::OUT_ONE))
        else $error("field value above one");

    // An empty output register never holds back the input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Reset leaves nothing in flight.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind compact_support_field_remap_unit csfr_checker u_csfr_checker (.*);

`default_nettype wire
